### hw/rtl/trcs_pkg.sv
// Shared types and constants for the triangle rotate, cull and shade block.
package trcs_pkg;

  localparam int TRIG_FRAC_BITS = 14;
  localparam int SHADE_BASE     = 128;
  localparam int NUM_REGS       = 8;
  localparam int SCR_W          = 12;
  localparam int SHADE_W        = 8;
  localparam int CENTER_W       = 10;
  localparam int TRIG_W         = 16;
  localparam int CRD_W          = 16;
  // Rotated coordinates grow by three bits in the first rotation stage and by two bits in each later one.
  localparam int R1_W           = 19;
  localparam int R2_W           = 21;
  localparam int R3_W           = 23;
  localparam int EDGE_W         = 24;
  localparam int NRM_W          = 49;

  // Register indexes
  localparam logic [2:0] REG_SIN_RX = 3'd0;
  localparam logic [2:0] REG_COS_RX = 3'd1;
  localparam logic [2:0] REG_SIN_RY = 3'd2;
  localparam logic [2:0] REG_COS_RY = 3'd3;
  localparam logic [2:0] REG_SIN_RZ = 3'd4;
  localparam logic [2:0] REG_COS_RZ = 3'd5;
  localparam logic [2:0] REG_CCOL   = 3'd6;
  localparam logic [2:0] REG_CROW   = 3'd7;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sz;
    logic signed [TRIG_W-1:0] cz;
    logic [CENTER_W-1:0]      ccol;
    logic [CENTER_W-1:0]      crow;
  } cfg_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } tri_t;

  typedef struct packed {
    logic                      visible;
    logic signed [SCR_W-1:0]   ax;
    logic signed [SCR_W-1:0]   ay;
    logic signed [SCR_W-1:0]   bx;
    logic signed [SCR_W-1:0]   by;
    logic signed [SCR_W-1:0]   cx;
    logic signed [SCR_W-1:0]   cy;
    logic [SHADE_W-1:0]        r;
    logic [SHADE_W-1:0]        g;
    logic [SHADE_W-1:0]        b;
  } res_t;

endpackage

### hw/rtl/trcs_rot.sv
// One rotation stage for three vertices: two rounded multiply-add pairs per vertex.
module trcs_rot #(
  parameter int IN_W  = 16,
  parameter int OUT_W = 19
) (
  input  logic                        clk,
  input  logic signed [3*IN_W-1:0]    in_p,
  input  logic signed [3*IN_W-1:0]    in_q,
  input  logic signed [3*IN_W-1:0]    in_k,
  input  logic signed [15:0]          c_m,
  input  logic signed [15:0]          s_m,
  output logic signed [3*OUT_W-1:0]   out_u,
  output logic signed [3*OUT_W-1:0]   out_v,
  output logic signed [3*IN_W-1:0]    out_k
);
  // u = round(p*c + q*s), v = round(p*s - q*c)
  localparam int PW = IN_W + 17;

  logic signed [3*OUT_W-1:0] u_r, v_r;
  logic signed [3*IN_W-1:0]  k_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [IN_W-1:0] p, q;
      logic signed [PW:0] su, sv;
      p  = in_p[i*IN_W +: IN_W];
      q  = in_q[i*IN_W +: IN_W];
      su = PW'(p) * PW'(c_m) + PW'(q) * PW'(s_m) + (PW+1)'(1 <<< 13);
      sv = PW'(p) * PW'(s_m) - PW'(q) * PW'(c_m) + (PW+1)'(1 <<< 13);
      u_r[i*OUT_W +: OUT_W] <= OUT_W'(su >>> trcs_pkg::TRIG_FRAC_BITS);
      v_r[i*OUT_W +: OUT_W] <= OUT_W'(sv >>> trcs_pkg::TRIG_FRAC_BITS);
    end
    k_r <= in_k;
  end

  assign out_u = u_r;
  assign out_v = v_r;
  assign out_k = k_r;
endmodule

### hw/rtl/trcs_front.sv
// Front end: APB register file, input acceptance and the three rotation stages.
module trcs_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  trcs_pkg::tri_t           in_tri,
  input  logic                     adv,
  output logic                     rot_valid,
  output logic signed [3*trcs_pkg::R3_W-1:0] rot_x,
  output logic signed [3*trcs_pkg::R3_W-1:0] rot_y,
  output logic signed [3*trcs_pkg::R3_W-1:0] rot_z,
  output trcs_pkg::cfg_t           cfg
);
  localparam int IW = trcs_pkg::CRD_W;
  localparam int W1 = trcs_pkg::R1_W;
  localparam int W2 = trcs_pkg::R2_W;
  localparam int W3 = trcs_pkg::R3_W;

  trcs_pkg::cfg_t cfg_r;
  logic [2:0] vld_r;
  logic [2:0] idx;

  assign idx = paddr[4:2];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sx   <= '0;
      cfg_r.cx   <= 16'sd16384;
      cfg_r.sy   <= '0;
      cfg_r.cy   <= 16'sd16384;
      cfg_r.sz   <= '0;
      cfg_r.cz   <= 16'sd16384;
      cfg_r.ccol <= 10'd160;
      cfg_r.crow <= 10'd100;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        trcs_pkg::REG_SIN_RX: cfg_r.sx   <= pwdata[15:0];
        trcs_pkg::REG_COS_RX: cfg_r.cx   <= pwdata[15:0];
        trcs_pkg::REG_SIN_RY: cfg_r.sy   <= pwdata[15:0];
        trcs_pkg::REG_COS_RY: cfg_r.cy   <= pwdata[15:0];
        trcs_pkg::REG_SIN_RZ: cfg_r.sz   <= pwdata[15:0];
        trcs_pkg::REG_COS_RZ: cfg_r.cz   <= pwdata[15:0];
        trcs_pkg::REG_CCOL:   cfg_r.ccol <= pwdata[9:0];
        trcs_pkg::REG_CROW:   cfg_r.crow <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      trcs_pkg::REG_SIN_RX: prdata = 32'(cfg_r.sx);
      trcs_pkg::REG_COS_RX: prdata = 32'(cfg_r.cx);
      trcs_pkg::REG_SIN_RY: prdata = 32'(cfg_r.sy);
      trcs_pkg::REG_COS_RY: prdata = 32'(cfg_r.cy);
      trcs_pkg::REG_SIN_RZ: prdata = 32'(cfg_r.sz);
      trcs_pkg::REG_COS_RZ: prdata = 32'(cfg_r.cz);
      trcs_pkg::REG_CCOL:   prdata = 32'(cfg_r.ccol);
      trcs_pkg::REG_CROW:   prdata = 32'(cfg_r.crow);
      default:              prdata = '0;
    endcase
  end

  // Pipeline advances as a whole when the queue has room or no rotated triangle waits
  assign in_ready = adv;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[1:0], in_valid};
  end

  logic signed [3*IW-1:0] vx, vy, vz;
  assign vx = {in_tri.c.x, in_tri.b.x, in_tri.a.x};
  assign vy = {in_tri.c.y, in_tri.b.y, in_tri.a.y};
  assign vz = {in_tri.c.z, in_tri.b.z, in_tri.a.z};

  logic signed [3*W1-1:0] x1, y1;
  logic signed [3*IW-1:0] z0;
  logic signed [3*W2-1:0] x2, z1;
  logic signed [3*W1-1:0] y1d;
  logic signed [3*W3-1:0] z2, y2;
  logic signed [3*W2-1:0] x2d;

  // Stages hold when the pipeline stalls: gate inputs via recirculation
  logic signed [3*IW-1:0] sx_in, sy_in, sz_in;
  logic signed [3*W1-1:0] s2p, s2k;
  logic signed [3*IW-1:0] s2q;
  logic signed [3*W2-1:0] s3p, s3k;
  logic signed [3*W1-1:0] s3q;

  logic signed [3*IW-1:0] hx_r, hy_r, hz_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      hx_r <= vx; hy_r <= vy; hz_r <= vz;
    end
  end
  assign sx_in = adv ? vx : hx_r;
  assign sy_in = adv ? vy : hy_r;
  assign sz_in = adv ? vz : hz_r;

  // Each stage's input is held; stage outputs recompute to the same value
  logic signed [3*W1-1:0] x1h_r, y1h_r;
  logic signed [3*IW-1:0] z0h_r;
  logic signed [3*W2-1:0] x2h_r, z1h_r;
  logic signed [3*W1-1:0] y1dh_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      x1h_r <= x1; y1h_r <= y1; z0h_r <= z0;
      x2h_r <= x2; z1h_r <= z1; y1dh_r <= y1d;
    end
  end
  assign s2p = adv ? x1 : x1h_r;
  assign s2q = adv ? z0 : z0h_r;
  assign s2k = adv ? y1 : y1h_r;
  assign s3p = adv ? z1 : z1h_r;
  assign s3q = adv ? y1d : y1dh_r;
  assign s3k = adv ? x2 : x2h_r;

  trcs_rot #(.IN_W(IW), .OUT_W(W1)) u_rz (
    .clk, .in_p(sx_in), .in_q(sy_in), .in_k(sz_in),
    .c_m(cfg_r.cz), .s_m(cfg_r.sz), .out_u(x1), .out_v(y1), .out_k(z0));

  logic signed [3*W2-1:0] z1n;
  // x2 = x1*cy + z*sy; z1 = x1*sy - z*cy
  trcs_rot #(.IN_W(W1), .OUT_W(W2)) u_ry (
    .clk, .in_p(s2p),
    .in_q({W1'(signed'(s2q[2*IW +: IW])), W1'(signed'(s2q[IW +: IW])),
           W1'(signed'(s2q[0 +: IW]))}),
    .in_k(s2k), .c_m(cfg_r.cy), .s_m(cfg_r.sy), .out_u(x2), .out_v(z1n), .out_k(y1d));
  assign z1 = z1n;

  logic signed [3*W2-1:0] x2k;
  // z2 = z1*cx + y1*sx; y2 = z1*sx - y1*cx
  trcs_rot #(.IN_W(W2), .OUT_W(W3)) u_rx (
    .clk, .in_p(s3p),
    .in_q({W2'(signed'(s3q[2*W1 +: W1])), W2'(signed'(s3q[W1 +: W1])),
           W2'(signed'(s3q[0 +: W1]))}),
    .in_k(s3k), .c_m(cfg_r.cx), .s_m(cfg_r.sx), .out_u(z2), .out_v(y2), .out_k(x2k));
  assign x2d = x2k;

  assign rot_valid = vld_r[2];
  assign rot_x = {W3'(signed'(x2d[2*W2 +: W2])), W3'(signed'(x2d[W2 +: W2])),
                  W3'(signed'(x2d[0 +: W2]))};
  assign rot_y = y2;
  assign rot_z = z2;
  assign cfg = cfg_r;
endmodule

### hw/rtl/trcs_back.sv
// Back end: edge cross product, culling, screen mapping and shading.
module trcs_back #(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  logic signed [3*trcs_pkg::R3_W-1:0] q_x,
  input  logic signed [3*trcs_pkg::R3_W-1:0] q_y,
  input  logic signed [3*trcs_pkg::R3_W-1:0] q_z,
  input  trcs_pkg::cfg_t           cfg,
  output logic                     out_valid,
  input  logic                     out_ready,
  output trcs_pkg::res_t           res
);
  localparam int W3 = trcs_pkg::R3_W;
  localparam int EW = trcs_pkg::EDGE_W;
  localparam int NW = trcs_pkg::NRM_W;
  localparam int FB = COORD_FRAC_BITS;

  // Stage 1: edges and screen coordinates
  logic s1_v_r, s2_v_r;
  logic signed [EW-1:0] tx1_r, ty1_r, tz1_r, tx2_r, ty2_r, tz2_r;
  trcs_pkg::res_t s1_res_r, s2_res_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r;
  logic adv;

  assign adv = !s2_v_r || out_ready;
  assign q_ready = adv;

  function automatic logic signed [11:0] scr(input logic [9:0] cen,
                                             input logic signed [W3-1:0] c);
    logic signed [W3-1:0] t;
    logic signed [W3+1:0] s;
    t = (c < 0) ? -((-c) >>> FB) : (c >>> FB);
    s = (W3+2)'(signed'({1'b0, cen})) + (W3+2)'(t);
    if (s > 2047) scr = 12'sd2047;
    else if (s < -2048) scr = -12'sd2048;
    else scr = s[11:0];
  endfunction

  function automatic logic [7:0] shd(input logic signed [NW-1:0] n);
    logic signed [NW-1:0] t;
    logic signed [NW:0] s;
    t = (n < 0) ? -((-n) >>> (2*FB+2)) : (n >>> (2*FB+2));
    s = (NW+1)'(t) + (NW+1)'(trcs_pkg::SHADE_BASE);
    if (s > 255) shd = 8'd255;
    else if (s < 0) shd = 8'd0;
    else shd = s[7:0];
  endfunction

  logic signed [W3-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  assign {cx, bx, ax} = q_x;
  assign {cy, by, ay} = q_y;
  assign {cz, bz, az} = q_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx1_r <= EW'(ax) - EW'(cx); ty1_r <= EW'(ay) - EW'(cy); tz1_r <= EW'(az) - EW'(cz);
      tx2_r <= EW'(bx) - EW'(cx); ty2_r <= EW'(by) - EW'(cy); tz2_r <= EW'(bz) - EW'(cz);
      s1_res_r.visible <= 1'b0;
      s1_res_r.ax <= scr(cfg.ccol, ax); s1_res_r.ay <= scr(cfg.crow, ay);
      s1_res_r.bx <= scr(cfg.ccol, bx); s1_res_r.by <= scr(cfg.crow, by);
      s1_res_r.cx <= scr(cfg.ccol, cx); s1_res_r.cy <= scr(cfg.crow, cy);
      s1_res_r.r <= '0; s1_res_r.g <= '0; s1_res_r.b <= '0;
      // Stage 2: cross product
      nx_r <= NW'(ty1_r) * NW'(tz2_r) - NW'(tz1_r) * NW'(ty2_r);
      ny_r <= NW'(tz1_r) * NW'(tx2_r) - NW'(tx1_r) * NW'(tz2_r);
      nz_r <= NW'(tx1_r) * NW'(ty2_r) - NW'(ty1_r) * NW'(tx2_r);
      s2_res_r <= s1_res_r;
    end
  end

  // Output: shade and cull from the registered normal
  always_comb begin
    res = s2_res_r;
    res.visible = (nz_r > 0);
    res.r = shd(nx_r);
    res.g = shd(ny_r);
    res.b = shd(nz_r);
  end
  assign out_valid = s2_v_r;
endmodule

### hw/rtl/trcs_queue.sv
// Two-entry queue of rotated triangles between front and back.
module trcs_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_valid,
  output logic                     wr_ready,
  input  logic [9*trcs_pkg::R3_W-1:0] wr_data,
  output logic                     rd_valid,
  input  logic                     rd_ready,
  output logic [9*trcs_pkg::R3_W-1:0] rd_data
);
  localparam int DW = 9*trcs_pkg::R3_W;
  logic [DW-1:0] mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule

### hw/rtl/triangle_rotate_cull_shade.sv
// Top level: triangle rotate, backface cull and normal shade.
// One triangle is accepted per clock when the output is taken every clock.
// A result passes three rotation stages (z, y, x axes, two multiply-add pairs
// per vertex each), a two-entry queue, then edge/screen and cross product;
// culling and shading are combinational on the cross-product register. The
// rotator pipeline stalls as a whole while the queue is full and a rotated
// triangle waits, and resumes in the cycle after the back end takes an entry;
// results hold while out_ready is low.
// Registers are at byte address 4*index over APB.
module triangle_rotate_cull_shade #(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_a_x, in_a_y, in_a_z,
  input  logic signed [15:0] in_b_x, in_b_y, in_b_z,
  input  logic signed [15:0] in_c_x, in_c_y, in_c_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_visible,
  output logic signed [11:0] out_scr_ax, out_scr_ay, out_scr_bx,
  output logic signed [11:0] out_scr_by, out_scr_cx, out_scr_cy,
  output logic [7:0]         out_shade_r, out_shade_g, out_shade_b
);
  localparam int W3 = trcs_pkg::R3_W;

  trcs_pkg::tri_t tri_in;
  trcs_pkg::cfg_t cfg;
  trcs_pkg::res_t res;
  logic rot_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  logic signed [3*W3-1:0] rot_x, rot_y, rot_z, q_x, q_y, q_z;
  logic [9*W3-1:0] q_out;
  logic adv;

  assign pready = 1'b1;
  assign tri_in = '{a: '{in_a_x, in_a_y, in_a_z},
                    b: '{in_b_x, in_b_y, in_b_z},
                    c: '{in_c_x, in_c_y, in_c_z}};

  // Stall the rotator only while a rotated triangle meets a full queue
  logic q_wr;
  assign adv = !rot_valid || q_wr_ready;
  assign q_wr = rot_valid && q_wr_ready;

  trcs_front u_front (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .in_valid, .in_ready, .in_tri(tri_in), .adv,
    .rot_valid, .rot_x, .rot_y, .rot_z, .cfg);

  // Carry all three rotated coordinates through the queue
  trcs_queue u_queue (
    .clk, .rst_n, .wr_valid(q_wr), .wr_ready(q_wr_ready),
    .wr_data({rot_x, rot_y, rot_z}), .rd_valid(q_rd_valid),
    .rd_ready(q_rd_ready), .rd_data(q_out));

  assign {q_x, q_y, q_z} = q_out;

  trcs_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid(q_rd_valid), .q_ready(q_rd_ready),
    .q_x, .q_y, .q_z, .cfg, .out_valid, .out_ready, .res);

  assign out_visible = res.visible;
  assign out_scr_ax = res.ax;
  assign out_scr_ay = res.ay;
  assign out_scr_bx = res.bx;
  assign out_scr_by = res.by;
  assign out_scr_cx = res.cx;
  assign out_scr_cy = res.cy;
  assign out_shade_r = res.r;
  assign out_shade_g = res.g;
  assign out_shade_b = res.b;
endmodule

### sim/tb_triangle_rotate_cull_shade.sv
// Testbench for the triangle rotate, cull and shade block: directed and random triangles vs. a predictor.
module tb_triangle_rotate_cull_shade;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_a_x = 0, in_a_y = 0, in_a_z = 0;
  logic signed [15:0] in_b_x = 0, in_b_y = 0, in_b_z = 0;
  logic signed [15:0] in_c_x = 0, in_c_y = 0, in_c_z = 0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_visible;
  logic signed [11:0] out_scr_ax, out_scr_ay, out_scr_bx, out_scr_by, out_scr_cx, out_scr_cy;
  logic [7:0] out_shade_r, out_shade_g, out_shade_b;

  triangle_rotate_cull_shade #(.COORD_FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_c_x(in_c_x), .in_c_y(in_c_y), .in_c_z(in_c_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_visible(out_visible),
    .out_scr_ax(out_scr_ax), .out_scr_ay(out_scr_ay), .out_scr_bx(out_scr_bx),
    .out_scr_by(out_scr_by), .out_scr_cx(out_scr_cx), .out_scr_cy(out_scr_cy),
    .out_shade_r(out_shade_r), .out_shade_g(out_shade_g), .out_shade_b(out_shade_b)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the registers
  trcs_pkg::cfg_t frame_cfg;
  trcs_pkg::tri_t pending_tris[$];
  trcs_pkg::res_t expected_frags[$];
  int errors = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;

  function automatic longint round_mac(longint p);
    return (p + (64'sd1 <<< (trcs_pkg::TRIG_FRAC_BITS - 1))) >>> trcs_pkg::TRIG_FRAC_BITS;
  endfunction

  function automatic longint trunc_div(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [11:0] screen_pos(longint ctr, longint crd);
    longint v;
    v = ctr + trunc_div(crd, FRAC);
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return v[11:0];
  endfunction

  function automatic logic [7:0] shade_of(longint n);
    longint v;
    v = trcs_pkg::SHADE_BASE + trunc_div(n, 2 * FRAC + 2);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic trcs_pkg::res_t shade_triangle(trcs_pkg::tri_t t, trcs_pkg::cfg_t c);
    longint px[3], py[3], pz[3];
    longint x, y, z, x1, y1, x2, z1, sx, cx, sy, cy, sz, cz;
    longint tx1, ty1, tz1, tx2, ty2, tz2, nx, ny, nz;
    trcs_pkg::vtx_t vt[3];
    trcs_pkg::res_t r;
    vt[0] = t.a; vt[1] = t.b; vt[2] = t.c;
    sx = c.sx; cx = c.cx; sy = c.sy; cy = c.cy; sz = c.sz; cz = c.cz;
    for (int k = 0; k < 3; k++) begin
      x = vt[k].x; y = vt[k].y; z = vt[k].z;
      x1 = round_mac(x * cz + y * sz);
      y1 = round_mac(x * sz - y * cz);
      x2 = round_mac(x1 * cy + z * sy);
      z1 = round_mac(x1 * sy - z * cy);
      pz[k] = round_mac(z1 * cx + y1 * sx);
      py[k] = round_mac(z1 * sx - y1 * cx);
      px[k] = x2;
    end
    tx1 = px[0] - px[2]; ty1 = py[0] - py[2]; tz1 = pz[0] - pz[2];
    tx2 = px[1] - px[2]; ty2 = py[1] - py[2]; tz2 = pz[1] - pz[2];
    nx = ty1 * tz2 - tz1 * ty2;
    ny = tz1 * tx2 - tx1 * tz2;
    nz = tx1 * ty2 - ty1 * tx2;
    r.visible = (nz > 0);
    r.ax = screen_pos(longint'(c.ccol), px[0]); r.ay = screen_pos(longint'(c.crow), py[0]);
    r.bx = screen_pos(longint'(c.ccol), px[1]); r.by = screen_pos(longint'(c.crow), py[1]);
    r.cx = screen_pos(longint'(c.ccol), px[2]); r.cy = screen_pos(longint'(c.crow), py[2]);
    r.r = shade_of(nx); r.g = shade_of(ny); r.b = shade_of(nz);
    return r;
  endfunction

  // Record each input transaction at its accepting edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_frags.push_back(shade_triangle({in_a_x, in_a_y, in_a_z, in_b_x, in_b_y,
                                               in_b_z, in_c_x, in_c_y, in_c_z}, frame_cfg));
    end
  end

  // Driver: bursts of transactions with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          trcs_pkg::tri_t t;
          t = pending_tris.pop_front();
          {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z} <= t;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: mode changes every so often
  int stall_mode = 0, stall_count = 0;
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_count = $urandom_range(5, 60);
    end
    stall_count--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_frags.size() == 0) begin
          $display("%0t: unexpected result vis=%0d ax=%0d", $time, out_visible, out_scr_ax);
          errors++;
        end else begin
          trcs_pkg::res_t e, a;
          e = expected_frags.pop_front();
          a = {out_visible, out_scr_ax, out_scr_ay, out_scr_bx, out_scr_by, out_scr_cx,
               out_scr_cy, out_shade_r, out_shade_g, out_shade_b};
          if (e.visible !== a.visible) begin
            $display("%0t: visible exp %0d got %0d", $time, e.visible, a.visible); errors++;
          end
          if (e.ax !== a.ax) begin
            $display("%0t: scr_ax exp %0d got %0d", $time, e.ax, a.ax); errors++;
          end
          if (e.ay !== a.ay) begin
            $display("%0t: scr_ay exp %0d got %0d", $time, e.ay, a.ay); errors++;
          end
          if (e.bx !== a.bx) begin
            $display("%0t: scr_bx exp %0d got %0d", $time, e.bx, a.bx); errors++;
          end
          if (e.by !== a.by) begin
            $display("%0t: scr_by exp %0d got %0d", $time, e.by, a.by); errors++;
          end
          if (e.cx !== a.cx) begin
            $display("%0t: scr_cx exp %0d got %0d", $time, e.cx, a.cx); errors++;
          end
          if (e.cy !== a.cy) begin
            $display("%0t: scr_cy exp %0d got %0d", $time, e.cy, a.cy); errors++;
          end
          if (e.r !== a.r) begin
            $display("%0t: shade_r exp %0d got %0d", $time, e.r, a.r); errors++;
          end
          if (e.g !== a.g) begin
            $display("%0t: shade_g exp %0d got %0d", $time, e.g, a.g); errors++;
          end
          if (e.b !== a.b) begin
            $display("%0t: shade_b exp %0d got %0d", $time, e.b, a.b); errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Register write over the configuration port, predictor updated alongside
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      trcs_pkg::REG_SIN_RX: frame_cfg.sx = val[15:0];
      trcs_pkg::REG_COS_RX: frame_cfg.cx = val[15:0];
      trcs_pkg::REG_SIN_RY: frame_cfg.sy = val[15:0];
      trcs_pkg::REG_COS_RY: frame_cfg.cy = val[15:0];
      trcs_pkg::REG_SIN_RZ: frame_cfg.sz = val[15:0];
      trcs_pkg::REG_COS_RZ: frame_cfg.cz = val[15:0];
      trcs_pkg::REG_CCOL:   frame_cfg.ccol = val[9:0];
      default:              frame_cfg.crow = val[9:0];
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'($signed($urandom_range(0, 8191)) - 4096);
      1: return 16'($urandom);
      default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic logic [15:0] pick_trig();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      3: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_tris.size() > 0 || in_valid || expected_frags.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic queue_random(int n, int mode);
    trcs_pkg::tri_t t;
    for (int i = 0; i < n; i++) begin
      t = {pick_coord(mode), pick_coord(mode), pick_coord(mode), pick_coord(mode),
           pick_coord(mode), pick_coord(mode), pick_coord(mode), pick_coord(mode),
           pick_coord(mode)};
      pending_tris.push_back(t);
    end
  endtask

  initial begin
    frame_cfg = {16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 10'd160, 10'd100};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers, field extremes, front and back facing, overflow
    pending_tris.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_tris.push_back({16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_tris.push_back({16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_tris.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
                            16'h7FFF, 16'h8000, 16'h7FFF});
    pending_tris.push_back({16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF,
                            16'h8000, 16'h8000, 16'h8000});
    pending_tris.push_back({16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
                            16'hFFFF, 16'hFFFF, 16'h0001});
    pending_tris.push_back({16'sd128, -16'sd128, 16'sd5, -16'sd200, 16'sd90, 16'sd7,
                            16'sd1, -16'sd1, 16'sd0});
    wait_drained();

    // Extreme registers: out-of-range trig patterns, center at both ends
    write_reg(trcs_pkg::REG_SIN_RX, 32'h0000_7FFF);
    write_reg(trcs_pkg::REG_COS_RX, 32'h0000_8000);
    write_reg(trcs_pkg::REG_SIN_RY, 32'hFFFF_C000);
    write_reg(trcs_pkg::REG_COS_RY, 32'h0000_4000);
    write_reg(trcs_pkg::REG_SIN_RZ, 32'h0000_8000);
    write_reg(trcs_pkg::REG_COS_RZ, 32'h0000_7FFF);
    write_reg(trcs_pkg::REG_CCOL, 32'h0000_03FF);
    write_reg(trcs_pkg::REG_CROW, 32'h0000_0000);
    queue_random(10, 2);
    queue_random(10, 1);
    wait_drained();

    // Random phases with fresh register settings
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(trcs_pkg::REG_SIN_RX, {16'($urandom), pick_trig()});
      write_reg(trcs_pkg::REG_COS_RX, {16'($urandom), pick_trig()});
      write_reg(trcs_pkg::REG_SIN_RY, {16'($urandom), pick_trig()});
      write_reg(trcs_pkg::REG_COS_RY, {16'($urandom), pick_trig()});
      write_reg(trcs_pkg::REG_SIN_RZ, {16'($urandom), pick_trig()});
      write_reg(trcs_pkg::REG_COS_RZ, {16'($urandom), pick_trig()});
      write_reg(trcs_pkg::REG_CCOL, (ph == 0) ? 32'd0 : $urandom);
      write_reg(trcs_pkg::REG_CROW, (ph == 1) ? 32'h3FF : $urandom);
      for (int i = 0; i < 100; i++) queue_random(1, ($urandom_range(0, 9) < 6) ? 0 :
                                                  (($urandom_range(0, 5) == 0) ? 2 : 1));
      wait_drained();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

### files.f
hw/rtl/trcs_pkg.sv
hw/rtl/trcs_rot.sv
hw/rtl/trcs_front.sv
hw/rtl/trcs_back.sv
hw/rtl/trcs_queue.sv
hw/rtl/triangle_rotate_cull_shade.sv
sim/tb_triangle_rotate_cull_shade.sv
